/* hw/rtl/rsd_pkg.sv */
// Shared types and constants of the radial stick dead zone block.
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int unsigned AXIS_W = 16;  // raw and output axis width
  localparam int unsigned MAG_W  = 31;  // Q1.30 magnitude, holds 2^30
  localparam int unsigned SQ_W   = 62;  // Q2.60 squared length
  localparam int unsigned DZ_W   = 16;  // dead zone register, Q0.16

  localparam int unsigned SQ_N = 31;    // square root steps, one root bit each
  localparam int unsigned DV_N = 30;    // ratio divider steps after the top bit
  localparam int unsigned CD_N = 16;    // component divider steps

  localparam logic [MAG_W-1:0]  ONE_Q30  = 31'h4000_0000;
  localparam logic [DZ_W-1:0]   DZ_RESET = 16'd11796;
  localparam logic [AXIS_W-1:0] POS_MAX  = 16'h7FFF;

  typedef logic [DZ_W-1:0] dz_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] raw_x;
    logic signed [AXIS_W-1:0] raw_y;
  } stick_in_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] out_x;
    logic signed [AXIS_W-1:0] out_y;
    logic                     in_deadzone;
  } stick_out_t;

endpackage

/* hw/rtl/rsd_stream_if.sv */
// Valid/ready channel carrying one payload per transfer.
`timescale 1ns / 1ps

interface rsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/radial_stick_deadzone.sv */
// Radial stick dead zone with rescaling, fully pipelined.
`timescale 1ns / 1ps

// Takes one raw stick sample (raw_x, raw_y) per transfer on in_i and returns
// one rescaled sample on out_o. Each axis is normalized to Q1.30, the vector
// length is found by a restoring square root (one root bit per stage), the
// rescale ratio by a restoring divider (one quotient bit per stage), and each
// component by a second divider lane pair (16 stages). A new sample is taken
// every clock cycle while out_o is not stalled. From the input transfer a
// sample passes the normalize, square and sum registers, the square root
// stages, the ratio divider stages, the multiply register and the component
// divider stages, then the output register. A stall on out_o freezes the
// whole pipeline.
// The dead zone register (Q0.16, reset 11796, about 0.18) is written through
// cfg_i, which is always ready; write it only while no sample is in flight.
module radial_stick_deadzone (
  input  logic         clk_i,
  input  logic         rst_ni,
  rsd_stream_if.sink   cfg_i,
  rsd_stream_if.sink   in_i,
  rsd_stream_if.source out_o
);
  import rsd_pkg::*;

  // Per-lane magnitudes and signs; lane 0 is x, lane 1 is y.
  typedef struct packed {
    logic [1:0][MAG_W-1:0] mag;
    logic [1:0]            neg;
  } comp_t;

  // Q1.30 magnitude of a raw axis. Positive values divide by 32767:
  // r*2^30/32767 rounded = r*2^15 + r + (r >= 16384).
  function automatic logic [MAG_W-1:0] norm_axis(input logic [AXIS_W-1:0] raw);
    logic [AXIS_W-1:0] m;
    m = AXIS_W'(~raw + 16'd1);
    if (raw[AXIS_W-1]) return {m, 15'b0};
    return {raw[14:0], 15'b0} + {16'b0, raw[14:0]} + {30'b0, raw[14]};
  endfunction

  // ---------------------------------------------------------------- control
  dz_t  dz_q;
  logic en;
  logic out_vld_q;

  // whole pipeline moves unless the output holds a result nobody takes
  assign en          = !out_vld_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------- storage
  logic            a_vld_q;
  comp_t           a_c_q;

  logic            b_vld_q;
  comp_t           b_c_q;
  logic [SQ_W-1:0] b_sq_q [2];

  logic [SQ_N:0]   sq_vld_q;
  comp_t           sq_c_q    [0:SQ_N];
  logic [SQ_W-1:0] sq_val_q  [0:SQ_N];
  logic [32:0]     sq_rem_q  [0:SQ_N];
  logic [MAG_W-1:0] sq_root_q [0:SQ_N];
  logic [32:0]     sq_rem_d  [1:SQ_N];
  logic [MAG_W-1:0] sq_root_d [1:SQ_N];

  logic [DV_N:0]    dv_vld_q;
  comp_t            dv_c_q   [0:DV_N];
  logic [MAG_W-1:0] dv_len_q [0:DV_N];
  logic             dv_inz_q [0:DV_N];
  logic [MAG_W-1:0] dv_rem_q [0:DV_N];
  logic [MAG_W-1:0] dv_quo_q [0:DV_N];
  logic [MAG_W-1:0] dv_rem_d [1:DV_N];
  logic [MAG_W-1:0] dv_quo_d [1:DV_N];

  logic             m_vld_q;
  logic [1:0]       m_neg_q;
  logic [MAG_W-1:0] m_len_q;
  logic             m_inz_q;
  logic [SQ_W-1:0]  m_prod_q [2];

  logic [CD_N:0]     cd_vld_q;
  logic [1:0]        cd_neg_q [0:CD_N];
  logic [MAG_W-1:0]  cd_len_q [0:CD_N];
  logic              cd_inz_q [0:CD_N];
  logic [MAG_W-1:0]  cd_rem_q [0:CD_N][2];
  logic [CD_N-1:0]   cd_lo_q  [0:CD_N][2];
  logic [CD_N-1:0]   cd_quo_q [0:CD_N][2];
  logic [MAG_W-1:0]  cd_rem_d [1:CD_N][2];
  logic [CD_N-1:0]   cd_quo_d [1:CD_N][2];

  stick_out_t out_q;

  // ---------------------------------------------------------------- logic
  comp_t in_c;
  assign in_c.mag[0] = norm_axis(in_i.data.raw_x);
  assign in_c.mag[1] = norm_axis(in_i.data.raw_y);
  assign in_c.neg    = {in_i.data.raw_y[AXIS_W-1], in_i.data.raw_x[AXIS_W-1]};

  // square root: two radicand bits per step, one root bit out
  always_comb begin
    logic [34:0] sh;
    logic [34:0] tr;
    for (int k = 0; k < SQ_N; k++) begin
      sh = {sq_rem_q[k], sq_val_q[k][61-2*k], sq_val_q[k][60-2*k]};
      tr = {2'b00, sq_root_q[k], 2'b01};
      if (sh >= tr) begin
        sq_rem_d[k+1]  = 33'(sh - tr);
        sq_root_d[k+1] = {sq_root_q[k][29:0], 1'b1};
      end else begin
        sq_rem_d[k+1]  = 33'(sh);
        sq_root_d[k+1] = {sq_root_q[k][29:0], 1'b0};
      end
    end
  end

  // dead zone test and ratio divider setup
  logic [MAG_W-1:0] dz30;
  logic [MAG_W-1:0] dvsr;
  logic [MAG_W-1:0] len;
  logic [MAG_W-1:0] clamp;
  logic [MAG_W-1:0] num0;
  logic             inz;
  logic             top_bit;

  assign dz30    = {1'b0, dz_q, 14'b0};
  assign dvsr    = ONE_Q30 - dz30;
  assign len     = sq_root_q[SQ_N];
  assign inz     = len <= dz30;
  assign clamp   = (len > ONE_Q30) ? ONE_Q30 : len;
  assign num0    = inz ? '0 : clamp - dz30;
  assign top_bit = num0 == dvsr;   // ratio of exactly one

  always_comb begin
    logic [MAG_W:0] sh;
    logic           ge;
    for (int k = 0; k < DV_N; k++) begin
      sh = {dv_rem_q[k], 1'b0};
      ge = sh >= {1'b0, dvsr};
      dv_rem_d[k+1] = ge ? MAG_W'(sh - {1'b0, dvsr}) : MAG_W'(sh);
      dv_quo_d[k+1] = dv_quo_q[k];
      dv_quo_d[k+1][DV_N-1-k] = ge;
    end
  end

  // component: ((n*R + L*2^14) >> 15) / L, one quotient bit per step
  logic [SQ_W-1:0] cd_num [2];
  assign cd_num[0] = m_prod_q[0] + {17'b0, m_len_q, 14'b0};
  assign cd_num[1] = m_prod_q[1] + {17'b0, m_len_q, 14'b0};

  always_comb begin
    logic [MAG_W:0] sh;
    logic           ge;
    for (int k = 0; k < CD_N; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh = {cd_rem_q[k][l], cd_lo_q[k][l][CD_N-1-k]};
        ge = sh >= {1'b0, cd_len_q[k]};
        cd_rem_d[k+1][l] = ge ? MAG_W'(sh - {1'b0, cd_len_q[k]}) : MAG_W'(sh);
        cd_quo_d[k+1][l] = cd_quo_q[k][l];
        cd_quo_d[k+1][l][CD_N-1-k] = ge;
      end
    end
  end

  // sign, saturation at plus one, dead zone force
  logic [AXIS_W-1:0] res [2];
  always_comb begin
    logic [AXIS_W-1:0] q;
    for (int l = 0; l < 2; l++) begin
      q = cd_quo_q[CD_N][l];
      if (cd_inz_q[CD_N]) begin
        res[l] = '0;
      end else if (cd_neg_q[CD_N][l]) begin
        res[l] = AXIS_W'(16'd0 - q);
      end else begin
        res[l] = q[AXIS_W-1] ? POS_MAX : q;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q      <= DZ_RESET;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      m_vld_q   <= 1'b0;
      cd_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) dz_q <= cfg_i.data;
      if (en) begin
        a_vld_q   <= in_i.valid;
        b_vld_q   <= a_vld_q;
        sq_vld_q  <= {sq_vld_q[SQ_N-1:0], b_vld_q};
        dv_vld_q  <= {dv_vld_q[DV_N-1:0], sq_vld_q[SQ_N]};
        m_vld_q   <= dv_vld_q[DV_N];
        cd_vld_q  <= {cd_vld_q[CD_N-1:0], m_vld_q};
        out_vld_q <= cd_vld_q[CD_N];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q <= in_c;

      b_c_q    <= a_c_q;
      b_sq_q[0] <= {31'b0, a_c_q.mag[0]} * {31'b0, a_c_q.mag[0]};
      b_sq_q[1] <= {31'b0, a_c_q.mag[1]} * {31'b0, a_c_q.mag[1]};

      sq_c_q[0]    <= b_c_q;
      sq_val_q[0]  <= b_sq_q[0] + b_sq_q[1];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      for (int k = 1; k <= SQ_N; k++) begin
        sq_c_q[k]    <= sq_c_q[k-1];
        sq_val_q[k]  <= sq_val_q[k-1];
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
      end

      dv_c_q[0]   <= sq_c_q[SQ_N];
      dv_len_q[0] <= len;
      dv_inz_q[0] <= inz;
      dv_rem_q[0] <= top_bit ? '0 : num0;
      dv_quo_q[0] <= {top_bit, 30'b0};
      for (int k = 1; k <= DV_N; k++) begin
        dv_c_q[k]   <= dv_c_q[k-1];
        dv_len_q[k] <= dv_len_q[k-1];
        dv_inz_q[k] <= dv_inz_q[k-1];
        dv_rem_q[k] <= dv_rem_d[k];
        dv_quo_q[k] <= dv_quo_d[k];
      end

      m_neg_q     <= dv_c_q[DV_N].neg;
      m_len_q     <= dv_len_q[DV_N];
      m_inz_q     <= dv_inz_q[DV_N];
      m_prod_q[0] <= {31'b0, dv_c_q[DV_N].mag[0]} * {31'b0, dv_quo_q[DV_N]};
      m_prod_q[1] <= {31'b0, dv_c_q[DV_N].mag[1]} * {31'b0, dv_quo_q[DV_N]};

      cd_neg_q[0] <= m_neg_q;
      cd_len_q[0] <= m_len_q;
      cd_inz_q[0] <= m_inz_q;
      for (int l = 0; l < 2; l++) begin
        cd_rem_q[0][l] <= cd_num[l][61:31];
        cd_lo_q[0][l]  <= cd_num[l][30:15];
        cd_quo_q[0][l] <= '0;
      end
      for (int k = 1; k <= CD_N; k++) begin
        cd_neg_q[k] <= cd_neg_q[k-1];
        cd_len_q[k] <= cd_len_q[k-1];
        cd_inz_q[k] <= cd_inz_q[k-1];
        for (int l = 0; l < 2; l++) begin
          cd_rem_q[k][l] <= cd_rem_d[k][l];
          cd_lo_q[k][l]  <= cd_lo_q[k-1][l];
          cd_quo_q[k][l] <= cd_quo_d[k][l];
        end
      end

      out_q.out_x       <= res[0];
      out_q.out_y       <= res[1];
      out_q.in_deadzone <= cd_inz_q[CD_N];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule
